// ===== hdl/bprq_pkg.sv =====
// Shared types, sizes and codes of the bounded priority ready queue.
package bprq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REQ_ENQ   = 2'd0;
  localparam logic [1:0] REQ_DEQ   = 2'd1;
  localparam logic [1:0] REQ_PURGE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] proc_id;
    logic [7:0] proc_priority;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic [4:0] entry_count;
    logic       is_empty;
  } rsp_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] pri;
  } entry_t;

endpackage

// ===== hdl/bprq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bprq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/bounded_priority_ready_queue_top.sv =====
// Top level of the bounded priority ready queue: sequencer, entry store and APB register.
// The queue holds up to QUEUE_DEPTH entries in a RAM in arrival order and serves one request
// at a time. An enqueue writes the RAM on acceptance and goes through the done state to the
// output register. A dequeue or purge walks the RAM through its single registered read port:
// it reads the scanned entries one a cycle (only the head for a FIFO-mode dequeue, all held
// entries for a priority dequeue, up to and through the last one for a purge), then closes
// the gap by reading and rewriting every entry behind the removed one, and then waits in the
// done state until the output register is free. The input is stalled while a request is in
// progress; the result sits in an output register, so a new request may be accepted while
// the previous result waits.
module bounded_priority_ready_queue_top
  import bprq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] data_idx_q, data_idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic             scan_more_q, scan_more_d;
  logic [CNT_W-1:0] pick_q, pick_d;
  entry_t           pick_ent_q, pick_ent_d;
  logic             found_q, found_d;
  logic [1:0]       status_q, status_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;
  logic             fifo_mode_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  logic             in_acc;
  logic             cfg_wr;
  logic [CNT_W-1:0] scan_last;
  logic             take;
  logic             found_n;
  logic [CNT_W-1:0] pick_n;
  logic [CNT_W-1:0] pick_n1;

  bprq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {31'd0, fifo_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      fifo_mode_q <= pwdata[0];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign scan_last = (req_q.req_type == REQ_DEQ && fifo_mode_q) ? '0 : occ_q - 1'b1;

  always_comb begin
    take = 1'b0;
    if (rd_pend_q) begin
      if (req_q.req_type == REQ_DEQ) begin
        take = (data_idx_q == '0) || (ram_rdata.pri < pick_ent_q.pri);
      end else begin
        take = !found_q && (ram_rdata.id == req_q.proc_id);
      end
    end
  end

  assign found_n = found_q || take;
  assign pick_n  = take ? data_idx_q : pick_q;
  assign pick_n1 = pick_n + 1'b1;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    occ_d       = occ_q;
    rd_idx_d    = rd_idx_q;
    data_idx_d  = data_idx_q;
    rd_pend_d   = 1'b0;
    scan_more_d = scan_more_q;
    pick_d      = pick_q;
    pick_ent_d  = pick_ent_q;
    found_d     = found_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = occ_q[IDX_W-1:0];
    ram_wdata   = '{id: in_data_i.proc_id, pri: in_data_i.proc_priority};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d       = in_data_i;
          pick_d      = '0;
          pick_ent_d  = '0;
          found_d     = 1'b0;
          rd_idx_d    = '0;
          scan_more_d = 1'b1;
          status_d    = ST_MISS;
          state_d     = S_DONE;
          case (in_data_i.req_type)
            REQ_ENQ: begin
              if (occ_q < CNT_W'(QUEUE_DEPTH)) begin
                ram_we   = 1'b1;
                occ_d    = occ_q + 1'b1;
                status_d = ST_DONE;
              end else begin
                status_d = ST_FULL;
              end
            end
            REQ_DEQ, REQ_PURGE: begin
              if (occ_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: begin
              status_d = ST_MISS;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_more_q) begin
          rd_pend_d   = 1'b1;
          data_idx_d  = rd_idx_q;
          rd_idx_d    = rd_idx_q + 1'b1;
          scan_more_d = (rd_idx_q != scan_last);
        end
        if (take) begin
          pick_d     = data_idx_q;
          pick_ent_d = ram_rdata;
          found_d    = 1'b1;
        end
        if (rd_pend_q && data_idx_q == scan_last) begin
          if (found_n) begin
            rd_idx_d    = pick_n1;
            scan_more_d = (pick_n1 < occ_q);
            state_d     = S_SHIFT;
          end else begin
            status_d = ST_MISS;
            state_d  = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (scan_more_q) begin
          rd_pend_d   = 1'b1;
          data_idx_d  = rd_idx_q;
          rd_idx_d    = rd_idx_q + 1'b1;
          scan_more_d = ((rd_idx_q + 1'b1) < occ_q);
        end
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(data_idx_q - 1'b1);
          ram_wdata = ram_rdata;
        end
        if (!scan_more_q && !rd_pend_q) begin
          occ_d    = occ_q - 1'b1;
          status_d = ST_DONE;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.out_id      = pick_ent_q.id;
          out_d.out_priority = pick_ent_q.pri;
          out_d.entry_count = 5'(occ_q);
          out_d.is_empty    = (occ_q == '0);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rd_pend_q   <= 1'b0;
      scan_more_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rd_pend_q   <= rd_pend_d;
      scan_more_q <= scan_more_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= rd_idx_d;
    data_idx_q <= data_idx_d;
    pick_q     <= pick_d;
    pick_ent_q <= pick_ent_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(QUEUE_DEPTH))
    else $error("Occupancy exceeds the queue depth.");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |-> (occ_q == $past(occ_q) + 1'b1 ||
                                 occ_q == $past(occ_q) - 1'b1))
    else $error("Occupancy moved by more than one entry.");

  a_full_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_q.status == ST_FULL) |-> (occ_q == CNT_W'(QUEUE_DEPTH)))
    else $error("Full status reported while the queue has room.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_DONE) |->
      (out_q.out_id == 8'd0 && out_q.out_priority == 8'd0))
    else $error("A failed request carries a removed entry.");

endmodule
